// ===== sv/yrr_pkg.sv =====
// Package for the YUV to RGB converter with rotation mapping.
// Holds the payload structs, register codes and conversion constants.
// No dependencies; the front, back and top level of the block import it.
package yrr_pkg;

  localparam int CHAN_W  = 8;
  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int IDX_W   = 24;
  localparam int SUM_W   = 22;
  localparam int DIM_MAX = 2 ** DIM_W - 1;

  // Configuration register indexes.
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_ROTATION_MODE = 2'd2;

  // Rotation codes.
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_90   = 2'd1;
  localparam logic [1:0] ROT_180  = 2'd2;
  localparam logic [1:0] ROT_270  = 2'd3;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // BT.601 coefficients scaled by 2^10.
  localparam int LUMA_OFS   = 16;
  localparam int CHROMA_OFS = 128;
  localparam int COEF_Y     = 1192;
  localparam int COEF_RV    = 1634;
  localparam int COEF_GV    = 833;
  localparam int COEF_GU    = 400;
  localparam int COEF_BU    = 2066;
  localparam int CHAN_SHIFT = 10;

  typedef struct packed {
    logic [CHAN_W-1:0] luma_sample;
    logic [CHAN_W-1:0] cb_sample;
    logic [CHAN_W-1:0] cr_sample;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [COORD_W-1:0] dest_col;
    logic [COORD_W-1:0] dest_row;
    logic [IDX_W-1:0]   dest_index;
    logic [DIM_W-1:0]   out_width;
    logic [DIM_W-1:0]   out_height;
    logic               last_pixel;
  } pix_out_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [1:0]       rotation_mode;
  } cfg_t;

  // Classified pixel passed from the front to the back.
  typedef struct packed {
    logic [CHAN_W-1:0]        luma_off;
    logic signed [CHAN_W-1:0] cb_off;
    logic signed [CHAN_W-1:0] cr_off;
    logic [DIM_W-1:0]         dest_col;
    logic [DIM_W-1:0]         dest_row;
    logic [DIM_W-1:0]         out_width;
    logic [DIM_W-1:0]         out_height;
    logic                     last_pixel;
  } mid_t;

endpackage

// ===== sv/yuv_to_rgb_rotate.sv =====
// YUV to RGB converter with rotation mapping, one pixel per clock unless
// stalled by a full queue. A pixel goes from the front into the middle
// queue, then the product stage register, then the result queue.
// Throughput: one pixel per cycle unless stalled, set by the single product stage.
// Reset (asynchronous, active low) empties both queues, zeroes the position
// counters and loads 640 x 480 with no rotation.
module yuv_to_rgb_rotate import yrr_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  pix_in_t          pix_i,
  output logic             empty,
  input  logic             pop,
  output pix_out_t         pix_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [DIM_W-1:0] cfg_data_i
);

  cfg_t     cfg_q;
  mid_t     front_item, mid_item;
  logic     mid_empty, mid_pop;
  logic     back_valid, out_full;
  pix_out_t back_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= FRAME_WIDTH_RST;
      cfg_q.frame_height  <= FRAME_HEIGHT_RST;
      cfg_q.rotation_mode <= ROT_NONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_data_i;
        REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_data_i;
        REG_ROTATION_MODE: cfg_q.rotation_mode <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  yrr_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .valid_i(push),
    .ready_i(!full),
    .pix_i  (pix_i),
    .item_o (front_item)
  );

  yrr_fifo #(
    .T    (mid_t),
    .DEPTH(2)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_item),
    .full_o (full),
    .pop_i  (mid_pop),
    .data_o (mid_item),
    .empty_o(mid_empty)
  );

  yrr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!mid_empty),
    .in_ready_o (mid_pop),
    .item_i     (mid_item),
    .out_valid_o(back_valid),
    .out_ready_i(!out_full),
    .pix_o      (back_pix)
  );

  yrr_fifo #(
    .T    (pix_out_t),
    .DEPTH(2)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (back_valid),
    .data_i (back_pix),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (pix_o),
    .empty_o(empty)
  );

`ifndef NO_ASSERTIONS
  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (DIM_W'(pix_o.dest_col) < pix_o.out_width))
    else $error("destination column outside output width");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (DIM_W'(pix_o.dest_row) < pix_o.out_height))
    else $error("destination row outside output height");

  // The final source pixel always lands in the first or last output column.
  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pix_o.last_pixel) |->
      (pix_o.dest_col == '0 ||
       pix_o.dest_col == COORD_W'(pix_o.out_width - 1'b1)))
    else $error("last pixel not on an edge column");
`endif

endmodule

// ===== sv/yrr_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
// Generic in payload type and depth; no package dependency.
module yrr_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/yrr_front.sv =====
// Front end: source position counters, rotation mapping and sample offsets.
// Depends on yrr_pkg for the config and classified pixel types.
module yrr_front import yrr_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    valid_i,
  input  logic    ready_i,
  input  pix_in_t pix_i,
  output mid_t    item_o
);

  localparam int CNT_W = ($clog2(MAX_DIM) > DIM_W) ? DIM_W : $clog2(MAX_DIM);
  localparam logic [DIM_W-1:0] DIM_CAP =
      (MAX_DIM > DIM_MAX) ? DIM_W'(DIM_MAX) : DIM_W'(MAX_DIM);

  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [DIM_W-1:0] eff_w, eff_h, col, row;
  logic             col_end, row_end, accept;

  assign accept = valid_i && ready_i;

  always_comb begin
    if (cfg_i.frame_width == '0) begin
      eff_w = DIM_W'(1);
    end else if (cfg_i.frame_width > DIM_CAP) begin
      eff_w = DIM_CAP;
    end else begin
      eff_w = cfg_i.frame_width;
    end
    if (cfg_i.frame_height == '0) begin
      eff_h = DIM_W'(1);
    end else if (cfg_i.frame_height > DIM_CAP) begin
      eff_h = DIM_CAP;
    end else begin
      eff_h = cfg_i.frame_height;
    end
    // A counter left beyond a shrunken frame restarts at zero.
    col = (DIM_W'(col_q) < eff_w) ? DIM_W'(col_q) : '0;
    row = (DIM_W'(row_q) < eff_h) ? DIM_W'(row_q) : '0;
    col_end = (col == eff_w - 1'b1);
    row_end = (row == eff_h - 1'b1);
  end

  always_comb begin
    if (!col_end) begin
      col_d = CNT_W'(col + 1'b1);
      row_d = CNT_W'(row);
    end else if (!row_end) begin
      col_d = '0;
      row_d = CNT_W'(row + 1'b1);
    end else begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_comb begin
    item_o.luma_off = (pix_i.luma_sample > CHAN_W'(LUMA_OFS)) ?
                      CHAN_W'(pix_i.luma_sample - CHAN_W'(LUMA_OFS)) : '0;
    item_o.cb_off   = signed'(CHAN_W'(pix_i.cb_sample - CHAN_W'(CHROMA_OFS)));
    item_o.cr_off   = signed'(CHAN_W'(pix_i.cr_sample - CHAN_W'(CHROMA_OFS)));
    item_o.last_pixel = col_end && row_end;
    case (cfg_i.rotation_mode)
      ROT_90: begin
        item_o.out_width  = eff_h;
        item_o.out_height = eff_w;
        item_o.dest_col   = eff_h - 1'b1 - row;
        item_o.dest_row   = col;
      end
      ROT_180: begin
        item_o.out_width  = eff_w;
        item_o.out_height = eff_h;
        item_o.dest_col   = eff_w - 1'b1 - col;
        item_o.dest_row   = eff_h - 1'b1 - row;
      end
      ROT_270: begin
        item_o.out_width  = eff_h;
        item_o.out_height = eff_w;
        item_o.dest_col   = row;
        item_o.dest_row   = eff_w - 1'b1 - col;
      end
      default: begin
        item_o.out_width  = eff_w;
        item_o.out_height = eff_h;
        item_o.dest_col   = col;
        item_o.dest_row   = row;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== sv/yrr_back.sv =====
// Back end: color matrix products and index multiply in one register stage,
// then sums, clamping and the index offset. Depends on yrr_pkg.
module yrr_back import yrr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mid_t     item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pix_out_t pix_o
);

  logic                    s1_valid_q;
  logic signed [SUM_W-1:0] y2_q, rv_q, gv_q, gu_q, bu_q;
  logic signed [SUM_W-1:0] y2_d, rv_d, gv_d, gu_d, bu_d;
  logic signed [SUM_W-1:0] yy_s, u_s, v_s;
  logic [2*DIM_W-1:0]      idx_prod;
  logic [IDX_W-1:0]        idx_q;
  logic [DIM_W-1:0]        dc_q, dr_q, ow_q, oh_q;
  logic                    last_q;
  logic signed [SUM_W-1:0] r_sum, g_sum, b_sum;

  function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] s);
    logic [CHAN_W-1:0] res;
    if (s[SUM_W-1]) begin
      res = '0;
    end else if (|s[SUM_W-2:CHAN_SHIFT+CHAN_W]) begin
      res = '1;
    end else begin
      res = s[CHAN_SHIFT+CHAN_W-1:CHAN_SHIFT];
    end
    return res;
  endfunction

  assign in_ready_o  = !s1_valid_q || out_ready_i;
  assign out_valid_o = s1_valid_q;

  always_comb begin
    yy_s = SUM_W'(item_i.luma_off);
    u_s  = SUM_W'(item_i.cb_off);
    v_s  = SUM_W'(item_i.cr_off);
    y2_d = yy_s * SUM_W'(COEF_Y);
    rv_d = v_s * SUM_W'(COEF_RV);
    gv_d = v_s * SUM_W'(COEF_GV);
    gu_d = u_s * SUM_W'(COEF_GU);
    bu_d = u_s * SUM_W'(COEF_BU);
    idx_prod = item_i.dest_row * item_i.out_width;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      y2_q   <= y2_d;
      rv_q   <= rv_d;
      gv_q   <= gv_d;
      gu_q   <= gu_d;
      bu_q   <= bu_d;
      idx_q  <= idx_prod[IDX_W-1:0];
      dc_q   <= item_i.dest_col;
      dr_q   <= item_i.dest_row;
      ow_q   <= item_i.out_width;
      oh_q   <= item_i.out_height;
      last_q <= item_i.last_pixel;
    end
  end

  always_comb begin
    r_sum = y2_q + rv_q;
    g_sum = y2_q - gv_q - gu_q;
    b_sum = y2_q + bu_q;
    pix_o.red        = clamp_chan(r_sum);
    pix_o.green      = clamp_chan(g_sum);
    pix_o.blue       = clamp_chan(b_sum);
    pix_o.dest_col   = dc_q[COORD_W-1:0];
    pix_o.dest_row   = dr_q[COORD_W-1:0];
    pix_o.dest_index = idx_q + IDX_W'(dc_q);
    pix_o.out_width  = ow_q;
    pix_o.out_height = oh_q;
    pix_o.last_pixel = last_q;
  end

endmodule
